### rtl/core/bcp_pkg.sv
// ----------------------------------------------------------------------------
// bcp_pkg
// Types, codes and defaults shared by the bytecode container parser.
// ----------------------------------------------------------------------------
package bcp_pkg;

	localparam int MAX_SECTIONS_DEF     = 16;
	localparam int MAX_INSTRUCTIONS_DEF = 1024;
	localparam int MAX_CONSTANTS_DEF    = 256;
	localparam int MAX_STRING_BYTES_DEF = 4096;

	localparam logic [7:0] MAGIC_B0 = 8'h41;
	localparam logic [7:0] MAGIC_B1 = 8'h49;
	localparam logic [7:0] MAGIC_B2 = 8'h42;
	localparam logic [7:0] MAGIC_B3 = 8'h43;
	localparam logic [31:0] MAGIC_WORD = {MAGIC_B3, MAGIC_B2, MAGIC_B1, MAGIC_B0};
	localparam logic [31:0] VERSION_WORD = 32'd1;

	localparam logic [23:0] HEADER_BYTES  = 24'd16;
	localparam logic [32:0] SEC_HDR_BYTES = 33'd8;
	localparam logic [23:0] INSTR_BYTES   = 24'd12;
	localparam logic [31:0] WORD_BYTES    = 32'd4;

	localparam logic [23:0] HDR_MAGIC_LAST   = 24'd3;
	localparam logic [23:0] HDR_VERSION_LAST = 24'd7;
	localparam logic [23:0] HDR_COUNT_LAST   = 24'd15;
	localparam logic [23:0] HDR_VERSION_OFS  = 24'd4;
	localparam logic [23:0] HDR_COUNT_OFS    = 24'd12;

	typedef enum logic [1:0] {
		CFG_IMAGE_LENGTH = 2'd0,
		CFG_INSTR_CODE   = 2'd1,
		CFG_CONST_CODE   = 2'd2,
		CFG_HIGH_OPCODE  = 2'd3
	} cfg_index_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_HDR, PH_SECHDR, PH_SKIP, PH_ICOUNT, PH_IOP, PH_IARG,
		PH_CCOUNT, PH_CKIND, PH_CINT, PH_CBOOL, PH_CSLEN, PH_CSTR
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0, ST_TRUNC = 4'd1, ST_MAGIC = 4'd2, ST_VERSION = 4'd3,
		ST_SECLIMIT = 4'd4, ST_OOB = 4'd5, ST_INVSEC = 4'd6, ST_ILIMIT = 4'd7,
		ST_OPCODE = 4'd8, ST_CLIMIT = 4'd9, ST_CKIND = 4'd10, ST_SLIMIT = 4'd11
	} status_t;

	typedef enum logic [1:0] {
		RK_SECTION = 2'd0, RK_INSTR = 2'd1, RK_CONST = 2'd2, RK_STATUS = 2'd3
	} rec_kind_t;

	localparam logic [7:0] CK_INT    = 8'd1;
	localparam logic [7:0] CK_BOOL   = 8'd2;
	localparam logic [7:0] CK_STRING = 8'd3;
	localparam logic [7:0] CK_VOID   = 8'd4;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         record_kind;
		logic [9:0]         entry_index;
		logic [31:0]        type_code;
		logic signed [63:0] value;
		logic [31:0]        size_field;
		logic [23:0]        offset_field;
		logic [3:0]         status;
		logic               last;
	} rec_t;

	typedef struct packed {
		logic [1:0] n;
		rec_t       r0;
		rec_t       r1;
	} push_t;

	function automatic rec_t mk_rec(rec_kind_t kind, logic [31:0] idx, logic [31:0] tcode,
		logic [63:0] val, logic [31:0] size, logic [23:0] ofs, status_t st, logic lst);
		rec_t r;
		r.record_kind  = kind;
		r.entry_index  = idx[9:0];
		r.type_code    = tcode;
		r.value        = val;
		r.size_field   = size;
		r.offset_field = ofs;
		r.status       = st;
		r.last         = lst;
		return r;
	endfunction

endpackage

### rtl/core/bcp_chan_if.sv
// ----------------------------------------------------------------------------
// bcp_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface bcp_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/bcp_out_fifo.sv
// ----------------------------------------------------------------------------
// bcp_out_fifo
// Four-entry record queue: takes up to two records a cycle, sends one while out_ch is ready.
// ----------------------------------------------------------------------------
module bcp_out_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  bcp_pkg::push_t push,
	output logic           room,
	bcp_chan_if.source     out_ch
);
	bcp_pkg::rec_t mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign out_ch.valid   = (cnt_q != 3'd0);
	assign out_ch.payload = mem_q[rp_q];
	assign pop            = out_ch.valid && out_ch.ready;
	assign room           = (cnt_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wp_q] <= push.r0;
		if (push.n == 2'd2) mem_q[wp_q + 2'd1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + push.n;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.n} - {2'b0, pop};
		end
	end
endmodule

### rtl/core/bytecode_container_parser.sv
// ----------------------------------------------------------------------------
// bytecode_container_parser
// Streaming parser for a sectioned bytecode container image.
// ----------------------------------------------------------------------------
// One image byte is taken every clock cycle while the four-entry record queue
// has room for two records; each byte is parsed in the cycle it is accepted
// and yields at most two records. String bytes and terminators go into an
// on-chip string store, one write port, with each terminator written the cycle
// after its string closes. A start beat restarts the load at any time.
module bytecode_container_parser #(
	parameter int MAX_SECTIONS     = bcp_pkg::MAX_SECTIONS_DEF,
	parameter int MAX_INSTRUCTIONS = bcp_pkg::MAX_INSTRUCTIONS_DEF,
	parameter int MAX_CONSTANTS    = bcp_pkg::MAX_CONSTANTS_DEF,
	parameter int MAX_STRING_BYTES = bcp_pkg::MAX_STRING_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	bcp_chan_if.sink    in_ch,
	bcp_chan_if.source  out_ch
);
	localparam int SecW   = $clog2(MAX_SECTIONS + 1);
	localparam int ItemMx = (MAX_INSTRUCTIONS > MAX_CONSTANTS) ? MAX_INSTRUCTIONS : MAX_CONSTANTS;
	localparam int ItemW  = $clog2(ItemMx + 1);
	localparam int FillW  = $clog2(MAX_STRING_BYTES + 1);
	localparam int AddrW  = $clog2(MAX_STRING_BYTES);

	logic [23:0] image_length_q;
	logic [31:0] instr_code_q, const_code_q, high_opcode_q;

	bcp_pkg::phase_t phase_q, phase_d;
	logic [23:0]      pos_q, pos_d, start_q, start_d;
	logic [63:0]      fa_q, fa_d, gfa;
	logic [3:0]       fbc_q, fbc_d, gcnt;
	logic [SecW-1:0]  secdecl_q, secdecl_d, secnum_q, secnum_d;
	logic [32:0]      end_q, end_d;
	logic             seen_i_q, seen_i_d, seen_c_q, seen_c_d;
	logic [ItemW-1:0] items_q, items_d, item_q, item_d;
	logic [31:0]      left_q, left_d, opcode_q, opcode_d;
	logic [FillW-1:0] fill_q, fill_d;
	logic             fin_q, fin_d;

	logic [7:0]  mem_q [MAX_STRING_BYTES];
	logic             wr_en, pend_d, pend_q;
	logic [AddrW-1:0] pend_addr_d, pend_addr_q;

	bcp_pkg::push_t push;
	bcp_pkg::rec_t  recs [2];
	logic [1:0]     nrec;
	logic           room, acc;
	logic [7:0]     b;

	logic            fin_req, do_next, do_close, do_open;
	bcp_pkg::status_t fin_st;
	logic [23:0]     fin_ofs;
	logic [31:0]     w, ix;
	logic [33:0]     need;

	assign in_ch.ready = room;
	assign acc         = in_ch.valid && room;
	assign b           = in_ch.payload.data_byte;

	always_comb begin
		gfa = fa_q;
		if (fbc_q < 4'd8) gfa[{fbc_q[2:0], 3'b000} +: 8] = fa_q[{fbc_q[2:0], 3'b000} +: 8] | b;
		gcnt = fbc_q + 4'd1;
	end

	always_comb begin
		phase_d = phase_q; pos_d = pos_q; start_d = start_q; fa_d = fa_q; fbc_d = fbc_q;
		secdecl_d = secdecl_q; secnum_d = secnum_q; end_d = end_q;
		seen_i_d = seen_i_q; seen_c_d = seen_c_q; items_d = items_q; item_d = item_q;
		left_d = left_q; opcode_d = opcode_q; fill_d = fill_q; fin_d = fin_q;
		recs[0] = '0; recs[1] = '0; nrec = 2'd0;
		wr_en = 1'b0; pend_d = 1'b0; pend_addr_d = pend_addr_q;
		fin_req = 1'b0; fin_st = bcp_pkg::ST_OK; fin_ofs = '0;
		do_next = 1'b0; do_close = 1'b0; do_open = 1'b0;
		w = gfa[31:0]; ix = '0; need = '0;
		if (acc) begin
			if (!in_ch.payload.mode) begin
				pos_d = '0; start_d = '0; fa_d = '0; fbc_d = '0; secdecl_d = '0;
				secnum_d = '0; end_d = '0; seen_i_d = 1'b0; seen_c_d = 1'b0;
				items_d = '0; item_d = '0; left_d = '0; opcode_d = '0; fill_d = '0;
				fin_d = 1'b0; phase_d = bcp_pkg::PH_HDR;
				if (image_length_q < bcp_pkg::HEADER_BYTES) begin
					fin_req = 1'b1; fin_st = bcp_pkg::ST_TRUNC; fin_ofs = image_length_q;
				end
			end else if (!fin_q) begin
				pos_d = pos_q + 24'd1;
				case (phase_q)
					bcp_pkg::PH_HDR: begin
						fa_d = gfa; fbc_d = gcnt;
						if (gcnt >= 4'd4) begin
							fa_d = '0; fbc_d = '0;
							if (pos_q == bcp_pkg::HDR_MAGIC_LAST) begin
								if (gfa != {32'd0, bcp_pkg::MAGIC_WORD}) begin
									fin_req = 1'b1; fin_st = bcp_pkg::ST_MAGIC;
								end
							end else if (pos_q == bcp_pkg::HDR_VERSION_LAST) begin
								if (gfa != {32'd0, bcp_pkg::VERSION_WORD}) begin
									fin_req = 1'b1; fin_st = bcp_pkg::ST_VERSION;
									fin_ofs = bcp_pkg::HDR_VERSION_OFS;
								end
							end else if (pos_q == bcp_pkg::HDR_COUNT_LAST) begin
								if (w > 32'(MAX_SECTIONS)) begin
									fin_req = 1'b1; fin_st = bcp_pkg::ST_SECLIMIT;
									fin_ofs = bcp_pkg::HDR_COUNT_OFS;
								end else begin
									secdecl_d = w[SecW-1:0]; secnum_d = '0; do_open = 1'b1;
								end
							end
						end
					end
					bcp_pkg::PH_SECHDR: begin
						fa_d = gfa; fbc_d = gcnt;
						if (gcnt >= 4'd8) begin
							start_d = pos_d;
							end_d = {9'd0, pos_d} + {1'b0, gfa[63:32]};
							if (end_d > {9'd0, image_length_q}) begin
								fin_req = 1'b1; fin_st = bcp_pkg::ST_OOB; fin_ofs = pos_d;
							end else begin
								ix = 32'(secnum_q);
								recs[0] = bcp_pkg::mk_rec(bcp_pkg::RK_SECTION, ix, w, 64'd0,
									gfa[63:32], pos_d, bcp_pkg::ST_OK, 1'b0);
								nrec = 2'd1;
								if (w == instr_code_q) begin
									if (seen_i_q || gfa[63:32] < bcp_pkg::WORD_BYTES) begin
										fin_req = 1'b1; fin_st = bcp_pkg::ST_INVSEC; fin_ofs = pos_d;
									end else begin
										seen_i_d = 1'b1; phase_d = bcp_pkg::PH_ICOUNT;
										fa_d = '0; fbc_d = '0;
									end
								end else if (w == const_code_q) begin
									if (seen_c_q || gfa[63:32] < bcp_pkg::WORD_BYTES) begin
										fin_req = 1'b1; fin_st = bcp_pkg::ST_INVSEC; fin_ofs = pos_d;
									end else begin
										seen_c_d = 1'b1; phase_d = bcp_pkg::PH_CCOUNT;
										fa_d = '0; fbc_d = '0;
									end
								end else if (gfa[63:32] == 32'd0) begin
									do_close = 1'b1;
								end else begin
									phase_d = bcp_pkg::PH_SKIP;
								end
							end
						end
					end
					bcp_pkg::PH_SKIP: begin
						if ({9'd0, pos_d} >= end_q) do_close = 1'b1;
					end
					bcp_pkg::PH_ICOUNT: begin
						fa_d = gfa; fbc_d = gcnt;
						if (gcnt >= 4'd4) begin
							if (w > 32'(MAX_INSTRUCTIONS)) begin
								fin_req = 1'b1; fin_st = bcp_pkg::ST_ILIMIT; fin_ofs = start_q;
							end else if (end_q - {9'd0, start_q} != 33'(bcp_pkg::WORD_BYTES)
									+ ({1'b0, w} << 3) + ({1'b0, w} << 2)) begin
								fin_req = 1'b1; fin_st = bcp_pkg::ST_INVSEC; fin_ofs = start_q;
							end else begin
								items_d = w[ItemW-1:0]; item_d = '0;
								if (w == 32'd0) begin
									do_close = 1'b1;
								end else begin
									phase_d = bcp_pkg::PH_IOP; fa_d = '0; fbc_d = '0;
								end
							end
						end
					end
					bcp_pkg::PH_IOP: begin
						fa_d = gfa; fbc_d = gcnt;
						if (gcnt >= 4'd4) begin
							opcode_d = w; phase_d = bcp_pkg::PH_IARG; fa_d = '0; fbc_d = '0;
						end
					end
					bcp_pkg::PH_IARG: begin
						fa_d = gfa; fbc_d = gcnt;
						if (gcnt >= 4'd8) begin
							if (opcode_q > high_opcode_q) begin
								fin_req = 1'b1; fin_st = bcp_pkg::ST_OPCODE;
								fin_ofs = pos_d - bcp_pkg::INSTR_BYTES;
							end else begin
								ix = 32'(item_q);
								recs[0] = bcp_pkg::mk_rec(bcp_pkg::RK_INSTR, ix, opcode_q, gfa,
									32'd0, 24'd0, bcp_pkg::ST_OK, 1'b0);
								nrec = 2'd1;
								item_d = item_q + 1'b1;
								if (item_d >= items_q) begin
									do_close = 1'b1;
								end else begin
									phase_d = bcp_pkg::PH_IOP; fa_d = '0; fbc_d = '0;
								end
							end
						end
					end
					bcp_pkg::PH_CCOUNT: begin
						fa_d = gfa; fbc_d = gcnt;
						if (gcnt >= 4'd4) begin
							if (w > 32'(MAX_CONSTANTS)) begin
								fin_req = 1'b1; fin_st = bcp_pkg::ST_CLIMIT; fin_ofs = start_q;
							end else begin
								items_d = w[ItemW-1:0]; item_d = '0; do_next = 1'b1;
							end
						end
					end
					bcp_pkg::PH_CKIND: begin
						case (b)
							bcp_pkg::CK_INT: begin
								if ({9'd0, pos_d} + 33'd8 > end_q) begin
									fin_req = 1'b1; fin_st = bcp_pkg::ST_INVSEC; fin_ofs = pos_d;
								end else begin
									phase_d = bcp_pkg::PH_CINT; fa_d = '0; fbc_d = '0;
								end
							end
							bcp_pkg::CK_BOOL: begin
								if ({9'd0, pos_d} + 33'd1 > end_q) begin
									fin_req = 1'b1; fin_st = bcp_pkg::ST_INVSEC; fin_ofs = pos_d;
								end else begin
									phase_d = bcp_pkg::PH_CBOOL; fa_d = '0; fbc_d = '0;
								end
							end
							bcp_pkg::CK_STRING: begin
								if ({9'd0, pos_d} + 33'(bcp_pkg::WORD_BYTES) > end_q) begin
									fin_req = 1'b1; fin_st = bcp_pkg::ST_INVSEC; fin_ofs = pos_d;
								end else begin
									phase_d = bcp_pkg::PH_CSLEN; fa_d = '0; fbc_d = '0;
								end
							end
							bcp_pkg::CK_VOID: begin
								ix = 32'(item_q);
								recs[0] = bcp_pkg::mk_rec(bcp_pkg::RK_CONST, ix, 32'(bcp_pkg::CK_VOID),
									64'd0, 32'd0, 24'd0, bcp_pkg::ST_OK, 1'b0);
								nrec = 2'd1;
								item_d = item_q + 1'b1; do_next = 1'b1;
							end
							default: begin
								fin_req = 1'b1; fin_st = bcp_pkg::ST_CKIND; fin_ofs = pos_q;
							end
						endcase
					end
					bcp_pkg::PH_CINT: begin
						fa_d = gfa; fbc_d = gcnt;
						if (gcnt >= 4'd8) begin
							ix = 32'(item_q);
							recs[0] = bcp_pkg::mk_rec(bcp_pkg::RK_CONST, ix, 32'(bcp_pkg::CK_INT),
								gfa, 32'd0, 24'd0, bcp_pkg::ST_OK, 1'b0);
							nrec = 2'd1;
							item_d = item_q + 1'b1; do_next = 1'b1;
						end
					end
					bcp_pkg::PH_CBOOL: begin
						ix = 32'(item_q);
						recs[0] = bcp_pkg::mk_rec(bcp_pkg::RK_CONST, ix, 32'(bcp_pkg::CK_BOOL),
							{63'd0, b != 8'd0}, 32'd0, 24'd0, bcp_pkg::ST_OK, 1'b0);
						nrec = 2'd1;
						item_d = item_q + 1'b1; do_next = 1'b1;
					end
					bcp_pkg::PH_CSLEN: begin
						fa_d = gfa; fbc_d = gcnt;
						need = 34'(fill_q) + {2'b0, w} + 34'd1;
						if (gcnt >= 4'd4) begin
							if ({9'd0, pos_d} + {1'b0, w} > end_q) begin
								fin_req = 1'b1; fin_st = bcp_pkg::ST_INVSEC; fin_ofs = pos_d;
							end else if (need > 34'(MAX_STRING_BYTES)) begin
								fin_req = 1'b1; fin_st = bcp_pkg::ST_SLIMIT; fin_ofs = pos_d;
							end else if (w == 32'd0) begin
								pend_d = (fill_q < FillW'(MAX_STRING_BYTES));
								pend_addr_d = fill_q[AddrW-1:0];
								ix = 32'(item_q);
								recs[0] = bcp_pkg::mk_rec(bcp_pkg::RK_CONST, ix,
									32'(bcp_pkg::CK_STRING), 64'(32'(fill_q)), 32'd0, 24'd0,
									bcp_pkg::ST_OK, 1'b0);
								nrec = 2'd1;
								fill_d = fill_q + 1'b1; item_d = item_q + 1'b1; do_next = 1'b1;
							end else begin
								left_d = w; fa_d = {32'd0, w}; phase_d = bcp_pkg::PH_CSTR;
							end
						end
					end
					bcp_pkg::PH_CSTR: begin
						wr_en = (fill_q < FillW'(MAX_STRING_BYTES));
						fill_d = fill_q + 1'b1;
						left_d = left_q - 32'd1;
						if (left_d == 32'd0) begin
							pend_d = (fill_d < FillW'(MAX_STRING_BYTES));
							pend_addr_d = fill_d[AddrW-1:0];
							ix = 32'(item_q);
							recs[0] = bcp_pkg::mk_rec(bcp_pkg::RK_CONST, ix,
								32'(bcp_pkg::CK_STRING), 64'(32'(fill_d) - fa_q[31:0]),
								fa_q[31:0], 24'd0, bcp_pkg::ST_OK, 1'b0);
							nrec = 2'd1;
							fill_d = fill_d + 1'b1; item_d = item_q + 1'b1; do_next = 1'b1;
						end
					end
					default: begin
						pos_d = pos_q;
					end
				endcase
			end
		end
		if (do_next) begin
			if (item_d >= items_d) begin
				if ({9'd0, pos_d} != end_d) begin
					fin_req = 1'b1; fin_st = bcp_pkg::ST_INVSEC; fin_ofs = pos_d;
				end else begin
					do_close = 1'b1;
				end
			end else if ({9'd0, pos_d} >= end_d) begin
				fin_req = 1'b1; fin_st = bcp_pkg::ST_INVSEC; fin_ofs = pos_d;
			end else begin
				phase_d = bcp_pkg::PH_CKIND; fa_d = '0; fbc_d = '0;
			end
		end
		if (do_close) begin
			secnum_d = secnum_d + 1'b1; do_open = 1'b1;
		end
		if (do_open) begin
			if (secnum_d >= secdecl_d) begin
				fin_req = 1'b1; fin_st = bcp_pkg::ST_OK; fin_ofs = '0;
			end else if ({9'd0, pos_d} + bcp_pkg::SEC_HDR_BYTES > {9'd0, image_length_q}) begin
				fin_req = 1'b1; fin_st = bcp_pkg::ST_TRUNC; fin_ofs = pos_d;
			end else begin
				phase_d = bcp_pkg::PH_SECHDR; fa_d = '0; fbc_d = '0;
			end
		end
		if (fin_req) begin
			phase_d = bcp_pkg::PH_IDLE; fin_d = 1'b1;
			recs[nrec[0]] = bcp_pkg::mk_rec(bcp_pkg::RK_STATUS, 32'd0, 32'd0, 64'd0, 32'd0,
				fin_ofs, fin_st, 1'b1);
			nrec = nrec + 2'd1;
		end
	end

	assign push.n  = nrec;
	assign push.r0 = recs[0];
	assign push.r1 = recs[1];

	bcp_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.out_ch (out_ch)
	);

	always_ff @(posedge clk) begin
		if (pend_q) begin
			mem_q[pend_addr_q] <= 8'd0;
		end else if (wr_en) begin
			mem_q[fill_q[AddrW-1:0]] <= b;
		end
		pend_addr_q <= pend_addr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_length_q <= '0;
			instr_code_q   <= 32'd1;
			const_code_q   <= 32'd2;
			high_opcode_q  <= '0;
		end else if (cfg_we) begin
			case (bcp_pkg::cfg_index_t'(cfg_index))
				bcp_pkg::CFG_IMAGE_LENGTH: image_length_q <= cfg_data[23:0];
				bcp_pkg::CFG_INSTR_CODE:   instr_code_q   <= cfg_data;
				bcp_pkg::CFG_CONST_CODE:   const_code_q   <= cfg_data;
				bcp_pkg::CFG_HIGH_OPCODE:  high_opcode_q  <= cfg_data;
				default:                   high_opcode_q  <= high_opcode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bcp_pkg::PH_IDLE; pos_q <= '0; start_q <= '0; fa_q <= '0;
			fbc_q <= '0; secdecl_q <= '0; secnum_q <= '0; end_q <= '0;
			seen_i_q <= 1'b0; seen_c_q <= 1'b0; items_q <= '0; item_q <= '0;
			left_q <= '0; opcode_q <= '0; fill_q <= '0; fin_q <= 1'b1; pend_q <= 1'b0;
		end else begin
			phase_q <= phase_d; pos_q <= pos_d; start_q <= start_d; fa_q <= fa_d;
			fbc_q <= fbc_d; secdecl_q <= secdecl_d; secnum_q <= secnum_d; end_q <= end_d;
			seen_i_q <= seen_i_d; seen_c_q <= seen_c_d; items_q <= items_d; item_q <= item_d;
			left_q <= left_d; opcode_q <= opcode_d; fill_q <= fill_d; fin_q <= fin_d;
			pend_q <= pend_d;
		end
	end
endmodule
